>>> rtl/core/slw_pkg.sv
`default_nettype none

package slw_pkg;

  // Input operation codes as they arrive on the op field.
  localparam logic [1:0] OP_EMBED_CHAR = 2'd0;
  localparam logic [1:0] OP_EMBED_END  = 2'd1;
  localparam logic [1:0] OP_EXTRACT    = 2'd2;
  localparam logic [1:0] OP_RESTART    = 2'd3;

  // Work classes handed from the front end to the back end.
  localparam logic [1:0] KIND_EMBED   = 2'd0;
  localparam logic [1:0] KIND_EXTRACT = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_START_INDEX = 1'b0;
  localparam logic CFG_PIXEL_COUNT = 1'b1;

  // End-of-message character and the largest image supported.
  localparam logic [6:0]  END_MARK   = 7'h04;
  localparam logic [24:0] MAX_PIXELS = 25'h100_0000;

  // Queue between the front end and the back end.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified transaction waiting for the back end.
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] value;
    logic       lsb;
  } slw_item_t;

  // Walk increment for each step phase: 1, 1, 2, 3, 5, 8.
  function automatic logic [3:0] walk_step(input logic [2:0] phase);
    logic [3:0] step;
    unique case (phase)
      3'd0:    step = 4'd1;
      3'd1:    step = 4'd1;
      3'd2:    step = 4'd2;
      3'd3:    step = 4'd3;
      3'd4:    step = 4'd5;
      3'd5:    step = 4'd8;
      default: step = 4'd1;
    endcase
    return step;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/slw_front.sv
`default_nettype none

module slw_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [1:0]            op,
  input  wire  [6:0]            message_char,
  input  wire                   lsb_in,
  output logic                  q_valid,
  output slw_pkg::slw_item_t    q_item,
  input  wire                   q_pop
);
  import slw_pkg::*;

  slw_item_t            entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;
  logic                 push;
  slw_item_t            item;

  // Classify the incoming transaction; the end marker becomes an ordinary embed.
  always_comb begin
    item.lsb = lsb_in;
    unique case (op)
      OP_EMBED_CHAR: begin
        item.kind  = KIND_EMBED;
        item.value = message_char;
      end
      OP_EMBED_END: begin
        item.kind  = KIND_EMBED;
        item.value = END_MARK;
      end
      OP_EXTRACT: begin
        item.kind  = KIND_EXTRACT;
        item.value = message_char;
      end
      default: begin
        item.kind  = KIND_RESTART;
        item.value = message_char;
      end
    endcase
  end

  assign in_stall = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/slw_back.sv
`default_nettype none

module slw_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire  [23:0]           start_index,
  input  wire  [24:0]           pixel_count,
  input  wire                   q_valid,
  input  slw_pkg::slw_item_t    q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [23:0]           pixel_index,
  output logic [1:0]            channel,
  output logic                  bit_value,
  output logic                  last,
  output logic                  error,
  output logic                  char_valid,
  output logic [6:0]            decoded_char,
  output logic                  message_done
);
  import slw_pkg::*;

  // Walk and extraction state.
  logic [24:0] walk_position, walk_position_next;
  logic [2:0]  step_phase, step_phase_next;
  logic [1:0]  channel_phase, channel_phase_next;
  logic [2:0]  bit_counter, bit_counter_next;
  logic [6:0]  char_accumulator, char_accumulator_next;
  logic        error_latched, error_latched_next;
  logic        done_latched, done_latched_next;

  // Embedding in progress.
  logic        busy, busy_next;
  logic [6:0]  emb_value, emb_value_next;
  logic [2:0]  emb_bit, emb_bit_next;

  logic [24:0] limit;
  logic        usable;
  logic [24:0] pos_adv;
  logic [2:0]  phase_adv;
  logic [1:0]  chan_adv;
  logic        adv_usable;
  logic        can_load;
  logic        go;
  logic [1:0]  cur_kind;
  logic [6:0]  cur_value;
  logic [2:0]  cur_bit;
  logic [6:0]  acc_new;

  logic [23:0] r_pix;
  logic [1:0]  r_ch;
  logic        r_bit;
  logic        r_last;
  logic        r_error;
  logic        r_cv;
  logic [6:0]  r_dc;
  logic        r_done;

  // Usable slots lie below the smaller of the pixel count and the largest image.
  assign limit      = (pixel_count > MAX_PIXELS) ? MAX_PIXELS : pixel_count;
  assign usable     = (walk_position < limit);
  assign pos_adv    = walk_position + 25'(walk_step(step_phase));
  assign phase_adv  = (step_phase == 3'd5) ? 3'd0 : step_phase + 3'd1;
  assign chan_adv   = (channel_phase == 2'd2) ? 2'd0 : channel_phase + 2'd1;
  assign adv_usable = (pos_adv < limit);

  // A result may be produced when the output register is empty or draining.
  assign can_load  = !out_valid || !out_stall;
  assign go        = (busy || q_valid) && can_load;
  assign q_pop     = !busy && q_valid && can_load;
  assign cur_kind  = busy ? KIND_EMBED : q_item.kind;
  assign cur_value = busy ? emb_value : q_item.value;
  assign cur_bit   = busy ? emb_bit : 3'd6;
  assign acc_new   = char_accumulator | (7'(q_item.lsb) << bit_counter);

  // Work out one result and the state that follows it.
  always_comb begin
    walk_position_next    = walk_position;
    step_phase_next       = step_phase;
    channel_phase_next    = channel_phase;
    bit_counter_next      = bit_counter;
    char_accumulator_next = char_accumulator;
    error_latched_next    = error_latched;
    done_latched_next     = done_latched;
    busy_next             = 1'b0;
    emb_value_next        = cur_value;
    emb_bit_next          = cur_bit - 3'd1;
    r_pix   = '0;
    r_ch    = '0;
    r_bit   = 1'b0;
    r_last  = 1'b1;
    r_error = 1'b0;
    r_cv    = 1'b0;
    r_dc    = '0;
    r_done  = 1'b0;
    unique case (cur_kind)
      KIND_EMBED: begin
        if (error_latched || !usable) begin
          error_latched_next = 1'b1;
          r_error            = 1'b1;
        end else begin
          r_pix              = walk_position[23:0];
          r_ch               = channel_phase;
          r_bit              = cur_value[cur_bit];
          r_last             = (cur_bit == 3'd0);
          busy_next          = (cur_bit != 3'd0);
          walk_position_next = pos_adv;
          step_phase_next    = phase_adv;
          channel_phase_next = chan_adv;
        end
      end
      KIND_EXTRACT: begin
        if (error_latched || done_latched) begin
          r_error = error_latched;
          r_done  = done_latched;
        end else if (!usable) begin
          error_latched_next = 1'b1;
          r_error            = 1'b1;
        end else begin
          walk_position_next = pos_adv;
          step_phase_next    = phase_adv;
          channel_phase_next = chan_adv;
          if (bit_counter == 3'd0) begin
            if (acc_new == END_MARK) begin
              done_latched_next = 1'b1;
              r_done            = 1'b1;
            end else begin
              r_cv = 1'b1;
              r_dc = acc_new;
            end
            char_accumulator_next = '0;
            bit_counter_next      = 3'd6;
          end else begin
            char_accumulator_next = acc_new;
            bit_counter_next      = bit_counter - 3'd1;
          end
          // Announce the next slot to read, if it is usable, unless the message has just ended.
          if (!(bit_counter == 3'd0 && acc_new == END_MARK) && adv_usable) begin
            r_pix = pos_adv[23:0];
            r_ch  = chan_adv;
          end
        end
      end
      default: begin
        walk_position_next    = {1'b0, start_index};
        step_phase_next       = '0;
        channel_phase_next    = '0;
        bit_counter_next      = 3'd6;
        char_accumulator_next = '0;
        error_latched_next    = 1'b0;
        done_latched_next     = 1'b0;
        if ({1'b0, start_index} < limit) begin
          r_pix = start_index;
        end
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_position    <= '0;
      step_phase       <= '0;
      channel_phase    <= '0;
      bit_counter      <= 3'd6;
      char_accumulator <= '0;
      error_latched    <= 1'b0;
      done_latched     <= 1'b0;
      busy             <= 1'b0;
      emb_value        <= '0;
      emb_bit          <= '0;
    end else if (go) begin
      walk_position    <= walk_position_next;
      step_phase       <= step_phase_next;
      channel_phase    <= channel_phase_next;
      bit_counter      <= bit_counter_next;
      char_accumulator <= char_accumulator_next;
      error_latched    <= error_latched_next;
      done_latched     <= done_latched_next;
      busy             <= busy_next;
      emb_value        <= emb_value_next;
      emb_bit          <= emb_bit_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (go) begin
      pixel_index  <= r_pix;
      channel      <= r_ch;
      bit_value    <= r_bit;
      last         <= r_last;
      error        <= r_error;
      char_valid   <= r_cv;
      decoded_char <= r_dc;
      message_done <= r_done;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lsb_stego_slot_walker_unit.sv
// Hides 7-bit characters in pixel least significant bits, or recovers them, along a slot walk
// that steps 1,1,2,3,5,8 from start_index while the channel rotates red, green, blue. An
// embed transaction (a character or the end marker) yields up to seven slot writes, one per
// cycle while the output is not stalled, most significant bit first; an extract or restart
// transaction yields one result. The back end's single walk unit produces one result per
// cycle while not stalled, so an embed holds it for up to seven results, others for one.
// A four-entry queue lets the input side keep accepting while results wait on a stalled
// output. Configuration writes belong in a quiet period with no transaction outstanding;
// each write sets one register, chosen by cfg_index; start_index acts only at a restart.
`default_nettype none

module lsb_stego_slot_walker_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  op,
  input  wire  [6:0]  message_char,
  input  wire         lsb_in,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [23:0] pixel_index,
  output logic [1:0]  channel,
  output logic        bit_value,
  output logic        last,
  output logic        error,
  output logic        char_valid,
  output logic [6:0]  decoded_char,
  output logic        message_done,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [24:0] cfg_data
);
  import slw_pkg::*;

  logic [23:0] start_index;
  logic [24:0] pixel_count;
  logic        q_valid;
  slw_item_t   q_item;
  logic        q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_index <= '0;
      pixel_count <= MAX_PIXELS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_INDEX: start_index <= cfg_data[23:0];
        default:         pixel_count <= cfg_data;
      endcase
    end
  end

  slw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .message_char (message_char),
    .lsb_in       (lsb_in),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  slw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .start_index  (start_index),
    .pixel_count  (pixel_count),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_index  (pixel_index),
    .channel      (channel),
    .bit_value    (bit_value),
    .last         (last),
    .error        (error),
    .char_valid   (char_valid),
    .decoded_char (decoded_char),
    .message_done (message_done)
  );

endmodule

`default_nettype wire
